[design/bbr_pkg.sv]
// Shared types and constants for the 7x7 RGB box blur.
// No dependencies; bbr_front, bbr_back, bbr_fifo and the top level import this package.
package bbr_pkg;

	localparam int ROW_W      = 16;
	localparam int CH_W       = 8;
	localparam int PIX_W      = 3 * CH_W;
	localparam int IMG_W_BITS = 11;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

	localparam logic [IMG_W_BITS-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [ROW_W-1:0]      HEIGHT_RESET = 16'd480;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [ROW_W-1:0] height;
		logic             frame_end;
	} job_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            frame_end;
	} res_t;

endpackage

[design/bbr_ram.sv]
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
module bbr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 8192,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[design/bbr_front.sv]
// Front end: configuration registers, position counters, row store writes and
// the decision whether an item yields a result. Depends on bbr_pkg.
module bbr_front #(
	parameter int MAX_WIDTH = 1024,
	parameter int RADIUS = 3,
	localparam int ROWS = 2 * RADIUS + 2,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int WW = $clog2(MAX_WIDTH + 1),
	localparam int SW = $clog2(ROWS),
	localparam int AW = $clog2(ROWS * MAX_WIDTH)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic                               opcode,
	input  logic [bbr_pkg::CH_W-1:0]           red_in,
	input  logic [bbr_pkg::CH_W-1:0]           green_in,
	input  logic [bbr_pkg::CH_W-1:0]           blue_in,
	input  logic                               wr_en,
	input  logic [bbr_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [bbr_pkg::CFG_DATA_W-1:0]     wr_data,
	input  logic                               back_idle,
	output logic                               start,
	output bbr_pkg::job_t                      job,
	output logic [CW-1:0]                      job_col,
	output logic [WW-1:0]                      job_width,
	output logic [SW-1:0]                      job_slot,
	output logic                               we,
	output logic [AW-1:0]                      waddr,
	output logic [bbr_pkg::PIX_W-1:0]          wdata
);
	import bbr_pkg::*;

	localparam int EW = (WW > IMG_W_BITS) ? WW : IMG_W_BITS;
	localparam int LW = ROW_W + WW + 1;

	logic [IMG_W_BITS-1:0] width_q;
	logic [ROW_W-1:0]      height_q;
	logic [CW-1:0]         in_col_q, out_col_q;
	logic [ROW_W-1:0]      in_row_q, out_row_q;
	logic [SW-1:0]         in_slot_q, out_slot_q;
	logic [LW-1:0]         in_lin_q, out_lin_q;

	logic [WW-1:0]    w;
	logic [ROW_W-1:0] h;
	logic [LW-1:0]    total, delay, n;
	logic             accept, is_pixel, done, do_write, past_end, emit, last_out, clear;
	logic [CW:0]      in_col_inc, out_col_inc;
	logic             in_wrap, out_wrap, cfg_hit;

	always_comb begin
		if (width_q == '0) begin
			w = WW'(1);
		end else if (EW'(width_q) > EW'(MAX_WIDTH)) begin
			w = WW'(MAX_WIDTH);
		end else begin
			w = WW'(width_q);
		end
	end

	assign h        = (height_q == '0) ? ROW_W'(1) : height_q;
	assign total    = LW'(w) * LW'(h);
	assign delay    = LW'(RADIUS) * LW'(w) + LW'(RADIUS);
	assign full     = ~back_idle;
	assign accept   = push & ~full;
	assign is_pixel = (opcode == OP_PIXEL);
	assign done     = (in_row_q >= h);
	assign do_write = accept & ~done & is_pixel;
	assign n        = do_write ? in_lin_q + LW'(1) : in_lin_q;
	assign past_end = (out_lin_q >= total);
	assign emit     = ~past_end & (done | (is_pixel & (n >= out_lin_q + delay + LW'(1))));
	assign last_out = (out_lin_q == total - LW'(1));
	assign start    = accept & emit;
	assign cfg_hit  = wr_en & ((wr_index == REG_WIDTH) || (wr_index == REG_HEIGHT));
	assign clear    = cfg_hit | (accept & past_end) | (start & last_out);

	assign in_col_inc  = (CW + 1)'(in_col_q) + (CW + 1)'(1);
	assign out_col_inc = (CW + 1)'(out_col_q) + (CW + 1)'(1);
	assign in_wrap     = (LW'(in_col_inc) >= LW'(w));
	assign out_wrap    = (LW'(out_col_inc) >= LW'(w));

	assign we    = do_write;
	assign waddr = AW'(in_slot_q) * AW'(MAX_WIDTH) + AW'(in_col_q);
	assign wdata = {red_in, green_in, blue_in};

	assign job.row       = out_row_q;
	assign job.height    = h;
	assign job.frame_end = last_out;
	assign job_col       = out_col_q;
	assign job_width     = w;
	assign job_slot      = out_slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (wr_en) begin
			if (wr_index == REG_WIDTH) begin
				width_q <= wr_data[IMG_W_BITS-1:0];
			end
			if (wr_index == REG_HEIGHT) begin
				height_q <= wr_data[ROW_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= '0;
			in_lin_q   <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
			out_lin_q  <= '0;
		end else if (clear) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= '0;
			in_lin_q   <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
			out_lin_q  <= '0;
		end else begin
			if (do_write) begin
				in_lin_q <= in_lin_q + LW'(1);
				if (in_wrap) begin
					in_col_q  <= '0;
					in_row_q  <= in_row_q + ROW_W'(1);
					in_slot_q <= (in_slot_q == SW'(ROWS - 1)) ? '0 : in_slot_q + SW'(1);
				end else begin
					in_col_q <= CW'(in_col_inc);
				end
			end
			if (start) begin
				out_lin_q <= out_lin_q + LW'(1);
				if (out_wrap) begin
					out_col_q  <= '0;
					out_row_q  <= out_row_q + ROW_W'(1);
					out_slot_q <= (out_slot_q == SW'(ROWS - 1)) ? '0 : out_slot_q + SW'(1);
				end else begin
					out_col_q <= CW'(out_col_inc);
				end
			end
		end
	end

endmodule

[design/bbr_back.sv]
// Back end: sweeps the window through the row store, accumulates the three
// channel sums and divides them by the pixel count. Depends on bbr_pkg.
module bbr_back #(
	parameter int MAX_WIDTH = 1024,
	parameter int RADIUS = 3,
	localparam int ROWS = 2 * RADIUS + 2,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int WW = $clog2(MAX_WIDTH + 1),
	localparam int SW = $clog2(ROWS),
	localparam int AW = $clog2(ROWS * MAX_WIDTH)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  bbr_pkg::job_t             job,
	input  logic [CW-1:0]             job_col,
	input  logic [WW-1:0]             job_width,
	input  logic [SW-1:0]             job_slot,
	output logic                      idle,
	output logic [AW-1:0]             raddr,
	input  logic [bbr_pkg::PIX_W-1:0] rdata,
	output logic                      res_push,
	output bbr_pkg::res_t             res,
	input  logic                      res_full
);
	import bbr_pkg::*;

	localparam int WIN  = 2 * RADIUS + 1;
	localparam int DW   = $clog2(WIN + 1);
	localparam int CNTW = $clog2(WIN * WIN + 1);
	localparam int SUMW = $clog2(255 * WIN * WIN + 1);
	localparam int STW  = $clog2(SUMW);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SETUP = 6'b000010,
		ST_SWEEP = 6'b000100,
		ST_FLUSH = 6'b001000,
		ST_DIV   = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t           state_q;
	logic [ROW_W-1:0] row_q, h_q;
	logic             fe_q;
	logic [CW-1:0]    col_q, c0_q, c1_q, cur_col_q;
	logic [WW-1:0]    w_q;
	logic [SW-1:0]    slot_q, cur_slot_q;
	logic [DW-1:0]    rows_left_q;
	logic [CNTW-1:0]  cnt_q;
	logic             rvalid_s1;
	logic [SUMW-1:0]  sum_q [3];
	logic [CNTW-1:0]  rem_q [3];
	logic [STW-1:0]   step_q;

	logic [ROW_W-1:0] r0, r1, hm1;
	logic [ROW_W:0]   rtop;
	logic [DW-1:0]    nrows, ncols;
	logic [SW-1:0]    d, s0;
	logic [CW-1:0]    c0, c1;
	logic [CW:0]      ctop, wm1;
	logic             row_end;
	logic [CNTW:0]    rem_sh [3];
	logic             qbit [3];

	always_comb begin
		r0    = (row_q >= ROW_W'(RADIUS)) ? row_q - ROW_W'(RADIUS) : '0;
		rtop  = (ROW_W + 1)'(row_q) + (ROW_W + 1)'(RADIUS);
		hm1   = h_q - ROW_W'(1);
		r1    = (rtop > (ROW_W + 1)'(hm1)) ? hm1 : rtop[ROW_W-1:0];
		nrows = DW'(r1 - r0 + ROW_W'(1));
		d     = SW'(row_q - r0);
		s0    = (slot_q >= d) ? slot_q - d
		        : SW'((SW + 1)'(slot_q) + (SW + 1)'(ROWS) - (SW + 1)'(d));
		c0    = (col_q >= CW'(RADIUS)) ? col_q - CW'(RADIUS) : '0;
		ctop  = (CW + 1)'(col_q) + (CW + 1)'(RADIUS);
		wm1   = (CW + 1)'(w_q - WW'(1));
		c1    = (ctop > wm1) ? CW'(wm1) : CW'(ctop);
		ncols = DW'(c1 - c0 + CW'(1));
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rem_sh[i] = {rem_q[i], sum_q[i][SUMW-1]};
			qbit[i]   = (rem_sh[i] >= (CNTW + 1)'(cnt_q));
		end
	end

	assign row_end  = (cur_col_q == c1_q);
	assign raddr    = AW'(cur_slot_q) * AW'(MAX_WIDTH) + AW'(cur_col_q);
	assign idle     = (state_q == ST_IDLE);
	assign res_push = (state_q == ST_DONE) & ~res_full;

	assign res.red       = sum_q[0][CH_W-1:0];
	assign res.green     = sum_q[1][CH_W-1:0];
	assign res.blue      = sum_q[2][CH_W-1:0];
	assign res.frame_end = fe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rvalid_s1 <= 1'b0;
		end else begin
			rvalid_s1 <= (state_q == ST_SWEEP);
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: state_q <= ST_SWEEP;
				ST_SWEEP: begin
					if (row_end && rows_left_q == DW'(1)) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: state_q <= ST_DIV;
				ST_DIV: begin
					if (step_q == STW'(SUMW - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!res_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			row_q  <= job.row;
			h_q    <= job.height;
			fe_q   <= job.frame_end;
			col_q  <= job_col;
			w_q    <= job_width;
			slot_q <= job_slot;
		end
		if (state_q == ST_SETUP) begin
			c0_q        <= c0;
			c1_q        <= c1;
			cur_col_q   <= c0;
			cur_slot_q  <= s0;
			rows_left_q <= nrows;
			cnt_q       <= CNTW'(nrows) * CNTW'(ncols);
			step_q      <= '0;
			for (int i = 0; i < 3; i++) begin
				sum_q[i] <= '0;
				rem_q[i] <= '0;
			end
		end
		if (state_q == ST_SWEEP) begin
			if (row_end) begin
				cur_col_q   <= c0_q;
				cur_slot_q  <= (cur_slot_q == SW'(ROWS - 1)) ? '0 : cur_slot_q + SW'(1);
				rows_left_q <= rows_left_q - DW'(1);
			end else begin
				cur_col_q <= cur_col_q + CW'(1);
			end
		end
		if (rvalid_s1) begin
			for (int i = 0; i < 3; i++) begin
				sum_q[i] <= sum_q[i] + SUMW'(rdata[PIX_W - 1 - CH_W * i -: CH_W]);
			end
		end
		if (state_q == ST_DIV) begin
			step_q <= step_q + STW'(1);
			for (int i = 0; i < 3; i++) begin
				rem_q[i] <= qbit[i] ? CNTW'(rem_sh[i] - (CNTW + 1)'(cnt_q)) : CNTW'(rem_sh[i]);
				sum_q[i] <= {sum_q[i][SUMW-2:0], qbit[i]};
			end
		end
	end

endmodule

[design/bbr_fifo.sv]
// Two-entry result queue between the back end and the result ports.
// Depends on bbr_pkg.
module bbr_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  bbr_pkg::res_t din,
	output logic          wfull,
	input  logic          rd,
	output logic          rempty,
	output bbr_pkg::res_t dout
);
	import bbr_pkg::*;

	res_t       ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       do_wr, do_rd;

	assign wfull  = (cnt_q == 2'd2);
	assign rempty = (cnt_q == 2'd0);
	assign do_wr  = wr & ~wfull;
	assign do_rd  = rd & ~rempty;
	assign dout   = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			ent_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_wr) begin
				wp_q <= ~wp_q;
			end
			if (do_rd) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(do_wr) - 2'(do_rd);
		end
	end

endmodule

[design/box_blur_rgb_7x7_core.sv]
// Box blur top level. An item that gives no result leaves full low.
// An item that gives a result holds full while the back end goes through setup,
// one row store read per window pixel, a flush step, a bit-serial divide and the
// push into the result queue, which waits while that queue is full.
// Reset: counters cleared, width 640, height 480, result queue empty; row store not cleared.
module box_blur_rgb_7x7_core #(
	parameter int MAX_WIDTH = 1024,
	parameter int RADIUS = 3
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic                              opcode,
	input  logic [bbr_pkg::CH_W-1:0]          red_in,
	input  logic [bbr_pkg::CH_W-1:0]          green_in,
	input  logic [bbr_pkg::CH_W-1:0]          blue_in,
	output logic                              empty,
	input  logic                              pop,
	output logic [bbr_pkg::CH_W-1:0]          red_out,
	output logic [bbr_pkg::CH_W-1:0]          green_out,
	output logic [bbr_pkg::CH_W-1:0]          blue_out,
	output logic                              frame_end,
	input  logic                              wr_en,
	input  logic [bbr_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [bbr_pkg::CFG_DATA_W-1:0]    wr_data
);
	import bbr_pkg::*;

	localparam int ROWS = 2 * RADIUS + 2;
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int SW = $clog2(ROWS);
	localparam int AW = $clog2(ROWS * MAX_WIDTH);

	logic             back_idle, start, we, res_push, res_full;
	job_t             job;
	logic [CW-1:0]    job_col;
	logic [WW-1:0]    job_width;
	logic [SW-1:0]    job_slot;
	logic [AW-1:0]    waddr, raddr;
	logic [PIX_W-1:0] wdata, rdata;
	res_t             res, head;

	bbr_front #(.MAX_WIDTH(MAX_WIDTH), .RADIUS(RADIUS)) u_front (
		.clk, .arst_n, .push, .full, .opcode, .red_in, .green_in, .blue_in,
		.wr_en, .wr_index, .wr_data, .back_idle, .start, .job, .job_col,
		.job_width, .job_slot, .we, .waddr, .wdata
	);

	bbr_ram #(.WIDTH(PIX_W), .DEPTH(ROWS * MAX_WIDTH)) u_store (
		.clk, .we, .waddr, .wdata, .raddr, .rdata
	);

	bbr_back #(.MAX_WIDTH(MAX_WIDTH), .RADIUS(RADIUS)) u_back (
		.clk, .arst_n, .start, .job, .job_col, .job_width, .job_slot,
		.idle(back_idle), .raddr, .rdata, .res_push, .res, .res_full
	);

	bbr_fifo u_outq (
		.clk, .arst_n, .wr(res_push), .din(res), .wfull(res_full),
		.rd(pop), .rempty(empty), .dout(head)
	);

	assign red_out   = head.red;
	assign green_out = head.green;
	assign blue_out  = head.blue;
	assign frame_end = head.frame_end;

endmodule

[design/bbr_checker.sv]
// Port-level checks for the box blur top level, attached by bind.
// Depends on box_blur_rgb_7x7_core.
module bbr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic       empty,
	input logic       pop,
	input logic [7:0] red_out,
	input logic [7:0] green_out,
	input logic [7:0] blue_out,
	input logic       frame_end
);

	a_reset_state: assert property (@(posedge clk) !arst_n |-> (empty && !full))
		else $error("reset state wrong");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(red_out) && $stable(green_out)
			&& $stable(blue_out) && $stable(frame_end)))
		else $error("waiting result changed");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && !full && !push) |=> empty)
		else $error("result without pending work");

	a_busy_no_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && !full && push) |=> empty)
		else $error("result too early");

endmodule

bind box_blur_rgb_7x7_core bbr_checker u_chk (.*);
